@@ rtl/core/bdss_pkg.sv @@
`timescale 1ns / 1ps

package bdss_pkg;

    // Map geometry
    localparam int MAP_SIZE  = 2047;
    localparam int MIN_VALUE = -1023;
    localparam int MAX_VALUE = MIN_VALUE + MAP_SIZE - 1;

    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int IDX_W     = $clog2(MAP_SIZE + 1);
    localparam int NUM_WORDS = (MAP_SIZE + WORD_W - 1) / WORD_W;
    localparam int ROW_W     = IDX_W - BIT_W;

    localparam int VAL_IN_W  = 16;
    localparam int VAL_OUT_W = 11;
    localparam int TDATA_W   = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FETCH  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_UNDEF  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_DUP     = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FETCHED = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_FCHK,
        S_NOTE
    } t_state;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_enc;

    // Lowest set bit of a word
    function automatic t_enc lowest_set(input logic [WORD_W-1:0] word);
        t_enc res;
        res.found = 1'b0;
        res.pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (word[i]) begin
                res.found = 1'b1;
                res.pos   = BIT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/bitmap_dedup_sorted_set.sv @@
`timescale 1ns / 1ps

// Deduplicating sorted set over -1023..1023, held as a presence bitmap in a
// 64 x 32 word memory. Requests arrive on the slave stream (tuser = request
// kind, tdata = value); each request gives exactly one response on the master
// stream (tuser = status, tdata = value). Insert marks a value and answers
// new, duplicate or out of range; out-of-range values change nothing. Fetch
// scans upward from a cursor and returns the next present value, moving the
// cursor past it, so repeated fetches list the unique values in ascending
// order; once the map is exhausted every fetch answers "none" until a clear.
// Clear empties the map and rewinds the cursor by resetting the per-row valid
// flags, with no memory sweep. Insert, clear, undefined and out-of-range
// requests pass through the accept cycle and one sequencer state (an insert
// is one read-modify-write); a fetch scans the 32-bit rows in turn with the
// single priority encoder, covering 1..64 rows. The block takes
// one request at a time; a response waiting in the output register only
// holds the block back when the next response is ready to be written.
module bitmap_dedup_sorted_set
    import bdss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [TDATA_W-1:0]   i_s_axis_tdata,  // [15:0] value (signed)
    input  logic [1:0]           i_s_axis_tuser,  // [1:0] req_type

    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [TDATA_W-1:0]   o_m_axis_tdata,  // [10:0] out_value (signed), [15:11] zero
    output logic [2:0]           o_m_axis_tuser   // [2:0] status
);

    // Bitmap memory and per-row valid flags (an invalid row reads as zero)
    logic [WORD_W-1:0]    r_bitmap [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_valid, n_row_valid;
    logic [WORD_W-1:0]    r_rd_data;
    logic                 r_rd_valid;

    // Sequencer and request state
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_cursor, n_cursor;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [ROW_W-1:0]     r_scan_row, n_scan_row;
    logic [BIT_W-1:0]     r_lo, n_lo;
    t_status              r_note, n_note;

    // Output register
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [VAL_OUT_W-1:0] r_out_value, n_out_value;

    // Memory port controls
    logic                 rd_en, wr_en;
    logic [ROW_W-1:0]     rd_addr, wr_addr;
    logic [WORD_W-1:0]    wr_data;

    logic                 accept, out_free;
    t_req                 req;
    logic signed [VAL_IN_W-1:0] in_val;
    logic                 in_range;
    logic [VAL_IN_W-1:0]  in_off;
    logic [WORD_W-1:0]    rd_word, scan_word;
    logic                 ins_hit;
    t_enc                 enc;
    logic [IDX_W-1:0]     hit_pos;
    logic                 last_row;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign req      = t_req'(i_s_axis_tuser);
    assign in_val   = $signed(i_s_axis_tdata);
    assign in_range = (in_val >= MIN_VALUE) && (in_val <= MAX_VALUE);
    assign in_off   = i_s_axis_tdata - VAL_IN_W'(MIN_VALUE);

    assign rd_word   = r_rd_valid ? r_rd_data : '0;
    assign ins_hit   = rd_word[r_idx[BIT_W-1:0]];
    // mask off bits below the cursor on the first row of a scan
    assign scan_word = rd_word & ({WORD_W{1'b1}} << r_lo);
    assign enc       = lowest_set(scan_word);
    assign hit_pos   = {r_scan_row, enc.pos};
    assign last_row  = (r_scan_row == ROW_W'(NUM_WORDS - 1));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{(TDATA_W - VAL_OUT_W){1'b0}}, r_out_value};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_INSERT: n_state = in_range ? S_INS : S_NOTE;
                        REQ_FETCH:  n_state = S_FCHK;
                        default:    n_state = S_NOTE;
                    endcase
                end
            end
            S_INS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FCHK: begin
                if ((enc.found || last_row) && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_NOTE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_cursor     = r_cursor;
        n_row_valid  = r_row_valid;
        n_idx        = r_idx;
        n_scan_row   = r_scan_row;
        n_lo         = r_lo;
        n_note       = r_note;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        rd_en        = 1'b0;
        rd_addr      = r_scan_row;
        wr_en        = 1'b0;
        wr_addr      = r_idx[IDX_W-1:BIT_W];
        wr_data      = rd_word | (WORD_W'(1) << r_idx[BIT_W-1:0]);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_INSERT: begin
                            n_idx  = in_off[IDX_W-1:0];
                            n_note = ST_RANGE;
                            if (in_range) begin
                                rd_en   = 1'b1;
                                rd_addr = in_off[IDX_W-1:BIT_W];
                            end
                        end
                        REQ_FETCH: begin
                            rd_en      = 1'b1;
                            rd_addr    = r_cursor[IDX_W-1:BIT_W];
                            n_scan_row = r_cursor[IDX_W-1:BIT_W];
                            n_lo       = r_cursor[BIT_W-1:0];
                        end
                        REQ_CLEAR: begin
                            n_row_valid = '0;
                            n_cursor    = '0;
                            n_note      = ST_NONE;
                        end
                        default: n_note = ST_NONE;
                    endcase
                end
            end
            S_INS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    if (ins_hit) begin
                        n_out_status = ST_DUP;
                    end else begin
                        n_out_status = ST_NEW;
                        wr_en        = 1'b1;
                        n_row_valid[r_idx[IDX_W-1:BIT_W]] = 1'b1;
                    end
                end
            end
            S_FCHK: begin
                if (enc.found) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_FETCHED;
                        n_out_value  = VAL_OUT_W'(hit_pos) + VAL_OUT_W'(MIN_VALUE);
                        n_cursor     = hit_pos + IDX_W'(1);
                    end
                end else if (last_row) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NONE;
                        n_out_value  = '0;
                        n_cursor     = IDX_W'(MAP_SIZE);
                    end
                end else begin
                    // step to the next row, full width
                    rd_en      = 1'b1;
                    rd_addr    = r_scan_row + ROW_W'(1);
                    n_scan_row = r_scan_row + ROW_W'(1);
                    n_lo       = '0;
                end
            end
            S_NOTE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_note;
                    n_out_value  = '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_scan_row   <= n_scan_row;
        r_lo         <= n_lo;
        r_note       <= n_note;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    // Bitmap memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bitmap[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data  <= r_bitmap[rd_addr];
            r_rd_valid <= r_row_valid[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= IDX_W'(MAP_SIZE))
        else $error("scan cursor beyond map");

    a_write_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_INS) && !ins_hit)
        else $error("bitmap written outside a new insert");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("ready right after an accepted request");

    a_fetch_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_FETCHED) |-> (r_out_value == '0))
        else $error("nonzero value on a non-fetch response");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");
`endif

endmodule

@@ tb/sv/tb_bitmap_dedup_sorted_set.sv @@
`timescale 1ns / 1ps

module tb_bitmap_dedup_sorted_set;
    import bdss_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 6;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int DRAIN_CYCLES  = 100;  // longest fetch scan reads all 64 rows
    localparam int MAX_REPORTS   = 10;

    // expected reply: status plus the tdata word (out_value, upper bits zero)
    typedef struct packed {
        t_status              status;
        logic [TDATA_W-1:0]   data;
    } t_set_reply;

    // one directed request; typed rows carry their reply, the rest use the predictor
    typedef struct packed {
        t_req                 req;
        logic [VAL_IN_W-1:0]  value;
        logic                 typed;
        t_set_reply           reply;
    } t_stim_row;

    localparam logic [VAL_IN_W-1:0] EDGE_VALUES [4] = '{
        16'hFC00, 16'hFC01, 16'h03FF, 16'h0400
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic [TDATA_W-1:0]   s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tready;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [TDATA_W-1:0]   m_tdata;
    wire  [2:0]           m_tuser;

    // shadow copy of the set
    bit                   presence_map [MAP_SIZE];
    int                   scan_cursor;

    t_set_reply           pending_replies [$];
    t_stim_row            directed_rows [DIRECTED_ROWS];
    int                   fail_count;
    int                   tx_calm;
    int                   rx_calm;

    bitmap_dedup_sorted_set dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [15:0] value (signed)
        .i_s_axis_tuser  (s_tuser),   // [1:0] req_type
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [10:0] out_value (signed), [15:11] zero
        .o_m_axis_tuser  (m_tuser)    // [2:0] status
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_set_reply make_reply(input t_status st, input int val);
        t_set_reply r;
        r.status = st;
        r.data   = '0;
        r.data[VAL_OUT_W-1:0] = val[VAL_OUT_W-1:0];
        return r;
    endfunction

    // Applies one request to the shadow set and returns the reply it gives
    function automatic t_set_reply predict_set_reply(input t_req req,
                                                     input logic [VAL_IN_W-1:0] value);
        int         v;
        int         i;
        t_set_reply r;
        r = make_reply(ST_NONE, 0);
        case (req)
            REQ_INSERT: begin
                v = int'($signed(value));
                if (v < MIN_VALUE || v > MAX_VALUE) begin
                    r = make_reply(ST_RANGE, 0);
                end else if (presence_map[v - MIN_VALUE]) begin
                    r = make_reply(ST_DUP, 0);
                end else begin
                    presence_map[v - MIN_VALUE] = 1'b1;
                    r = make_reply(ST_NEW, 0);
                end
            end
            REQ_FETCH: begin
                for (i = scan_cursor; i < MAP_SIZE; i++) begin
                    if (presence_map[i]) break;
                end
                if (i < MAP_SIZE) begin
                    scan_cursor = i + 1;
                    r = make_reply(ST_FETCHED, i + MIN_VALUE);
                end else begin
                    // exhausted: cursor parks at the end until a clear
                    scan_cursor = MAP_SIZE;
                end
            end
            REQ_CLEAR: begin
                presence_map = '{default: 1'b0};
                scan_cursor  = 0;
            end
            default: ;  // undefined code changes nothing
        endcase
        return r;
    endfunction

    // Idle length: mostly short, a few long, and calm stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [TDATA_W-1:0] want,
                                   input logic [TDATA_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input t_req req, input logic [VAL_IN_W-1:0] value,
                                input logic typed, input t_set_reply typed_reply);
        int         gap;
        t_set_reply predicted;
        t_set_reply expected;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        predicted = predict_set_reply(req, value);
        expected  = typed ? typed_reply : predicted;
        pending_replies = {pending_replies, expected};
        @(negedge i_clk);
    endtask

    // Sender holds off until every outstanding reply is back
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Reply checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply", '0, m_tdata);
            end else begin
                if (pending_replies[0].status != m_tuser)
                    report_mismatch("status", 16'(pending_replies[0].status), 16'(m_tuser));
                if (pending_replies[0].data != m_tdata)
                    report_mismatch("tdata", pending_replies[0].data, m_tdata);
                void'(pending_replies.pop_front());
            end
        end
    end

    // Receiver backpressure
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = pick_gap(rx_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int                  n;
        int                  r;
        int                  insert_pct;
        int                  window_base;
        t_req                req;
        logic [VAL_IN_W-1:0] val;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        fail_count  = 0;
        tx_calm     = 0;
        rx_calm     = 0;
        insert_pct  = 50;
        window_base = 0;
        scan_cursor = 0;
        presence_map = '{default: 1'b0};

        directed_rows = '{
            // empty after reset
            '{REQ_FETCH,  16'h0000, 1'b1, make_reply(ST_NONE, 0)},
            // range extremes and a duplicate
            '{REQ_INSERT, 16'hFC01, 1'b1, make_reply(ST_NEW, 0)},
            '{REQ_INSERT, 16'h03FF, 1'b1, make_reply(ST_NEW, 0)},
            '{REQ_INSERT, 16'hFC01, 1'b1, make_reply(ST_DUP, 0)},
            '{REQ_INSERT, 16'hFC00, 1'b1, make_reply(ST_RANGE, 0)},
            '{REQ_INSERT, 16'h0400, 1'b1, make_reply(ST_RANGE, 0)},
            '{REQ_INSERT, 16'h8000, 1'b1, make_reply(ST_RANGE, 0)},
            '{REQ_INSERT, 16'h7FFF, 1'b1, make_reply(ST_RANGE, 0)},
            '{REQ_INSERT, 16'h0000, 1'b0, make_reply(ST_NONE, 0)},
            '{REQ_INSERT, 16'hFFFF, 1'b0, make_reply(ST_NONE, 0)},
            // cursor still parked at the end by the empty fetch; value ignored
            '{REQ_FETCH,  16'hABCD, 1'b1, make_reply(ST_NONE, 0)},
            '{REQ_FETCH,  16'h0000, 1'b0, make_reply(ST_NONE, 0)},
            '{REQ_FETCH,  16'hFFFF, 1'b0, make_reply(ST_NONE, 0)},
            // insert behind the cursor stays hidden until a clear
            '{REQ_INSERT, 16'hFE0C, 1'b0, make_reply(ST_NONE, 0)},
            '{REQ_FETCH,  16'h0000, 1'b0, make_reply(ST_NONE, 0)},
            '{REQ_FETCH,  16'h0000, 1'b1, make_reply(ST_NONE, 0)},
            '{REQ_INSERT, 16'hFE0C, 1'b0, make_reply(ST_NONE, 0)},
            '{REQ_FETCH,  16'h0000, 1'b0, make_reply(ST_NONE, 0)},
            // undefined code, then clear
            '{REQ_UNDEF,  16'h5555, 1'b1, make_reply(ST_NONE, 0)},
            '{REQ_CLEAR,  16'hAAAA, 1'b1, make_reply(ST_NONE, 0)},
            '{REQ_FETCH,  16'h0000, 1'b1, make_reply(ST_NONE, 0)},
            '{REQ_INSERT, 16'hFE0C, 1'b0, make_reply(ST_NONE, 0)},
            '{REQ_INSERT, 16'h03FE, 1'b0, make_reply(ST_NONE, 0)},
            '{REQ_FETCH,  16'h0000, 1'b0, make_reply(ST_NONE, 0)},
            // cursor still parked at the end, so the scan reads only the top row
            '{REQ_FETCH,  16'h0000, 1'b0, make_reply(ST_NONE, 0)}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (n = 0; n < DIRECTED_ROWS; n++)
            send_request(directed_rows[n].req, directed_rows[n].value,
                         directed_rows[n].typed, directed_rows[n].reply);
        wait_for_replies();

        // Random: each block of 50 items draws its own insert share (20..85 percent)
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                insert_pct  = $urandom_range(20, 85);
                window_base = int'($urandom_range(0, 2006)) - 1023;
            end
            if (n == RANDOM_ITEMS / 2)
                wait_for_replies();
            r = $urandom_range(0, 99);
            if (r < insert_pct) begin
                req = REQ_INSERT;
                case ($urandom_range(0, 9))
                    0, 1:       val = 16'($urandom_range(0, 65535));
                    2:          val = EDGE_VALUES[$urandom_range(0, 3)];
                    3, 4, 5, 6: val = 16'(window_base + int'($urandom_range(0, 40)));
                    default:    val = 16'(int'($urandom_range(0, 2046)) - 1023);
                endcase
            end else begin
                val = 16'($urandom_range(0, 65535));
                if (r < 95)      req = REQ_FETCH;
                else if (r < 98) req = REQ_CLEAR;
                else             req = REQ_UNDEF;
            end
            send_request(req, val, 1'b0, make_reply(ST_NONE, 0));
        end

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            fail_count += pending_replies.size();
            $display("%0d replies never arrived", pending_replies.size());
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
